// ===== src/rbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsc_pkg: shared types and constants
// Item, configuration and sequencer types for the 2D rigid body step and
// collision block.
// ----------------------------------------------------------------------------
package rbsc_pkg;

    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 288;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CAND = 1'b1;

    localparam int FLG_SOLID = 0;
    localparam int FLG_KIN   = 1;
    localparam int FLG_GRAV  = 2;

    localparam logic [2:0] CFG_GX     = 3'd0;
    localparam logic [2:0] CFG_GY     = 3'd1;
    localparam logic [2:0] CFG_AIR    = 3'd2;
    localparam logic [2:0] CFG_FRIC   = 3'd3;
    localparam logic [2:0] CFG_BOUNCE = 3'd4;
    localparam logic [2:0] CFG_MASS   = 3'd5;
    localparam logic [2:0] CFG_ARATE  = 3'd6;
    localparam logic [2:0] CFG_FLAGS  = 3'd7;

    typedef enum logic [1:0] {
        K_TICK,
        K_CAND,
        K_IGN
    } t_kind;

    typedef struct packed {
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic [30:0]        air;
        logic [16:0]        fric;
        logic signed [17:0] bounce;
        logic [30:0]        mass;
        logic signed [31:0] arate;
        logic [2:0]         flags;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic               last;
        logic [30:0]        dt;
        logic signed [17:0] ax;
        logic signed [17:0] ay;
        logic signed [31:0] sep;
        logic               pk;
        logic [30:0]        pm;
        logic signed [31:0] pvx;
        logic signed [31:0] pvy;
    } t_item;

    typedef enum logic [5:0] {
        B_IDLE, B_TG, B_TA1, B_TA2, B_TP, B_TANG,
        B_C1, B_C2, B_C3, B_C4,
        B_R1, B_R2,
        B_K3, B_K4, B_K5, B_K6, B_K7, B_K8, B_K9, B_K10, B_K11, B_K12,
        B_DH1, B_DH2, B_DIV, B_DWAIT, B_D1, B_D2, B_D3,
        B_POS, B_EMIT
    } t_bstate;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -68'sh0_0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sadd(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        return sat32(68'(a) + 68'(b));
    endfunction

endpackage

// ===== src/rbsc_front.sv =====
// ----------------------------------------------------------------------------
// rbsc_front: input stage
// Accepts stream items, unpacks and classifies them, and queues them for
// the sequencer in a two-entry FIFO.
// ----------------------------------------------------------------------------
module rbsc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rbsc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  logic                             s_axis_tlast,
    input  rbsc_pkg::t_cfg                   i_cfg,
    output logic                             o_q_valid,
    output rbsc_pkg::t_item                  o_q_item,
    input  logic                             i_q_pop
);
    import rbsc_pkg::*;

    t_item      w_item;
    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    always_comb begin
        w_item.last = s_axis_tlast;
        w_item.dt   = s_axis_tdata[30:0];
        w_item.ax   = s_axis_tdata[48:31];
        w_item.ay   = s_axis_tdata[66:49];
        w_item.sep  = s_axis_tdata[98:67];
        w_item.pk   = s_axis_tdata[99];
        w_item.pm   = s_axis_tdata[130:100];
        w_item.pvx  = s_axis_tdata[162:131];
        w_item.pvy  = s_axis_tdata[194:163];
        if (s_axis_tuser == OP_TICK) begin
            w_item.kind = K_TICK;
        end else if (i_cfg.flags[FLG_SOLID] && !i_cfg.flags[FLG_KIN]) begin
            w_item.kind = K_CAND;
        end else begin
            w_item.kind = K_IGN;
        end
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_cnt != 2'd0);
    assign w_pop         = i_q_pop && o_q_valid;
    assign o_q_item      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ===== src/rbsc_div.sv =====
// ----------------------------------------------------------------------------
// rbsc_div: restoring divider
// Unsigned divide, one quotient bit per cycle; keeps the low quotient bits.
// ----------------------------------------------------------------------------
module rbsc_div #(
    parameter int NUM_W = 49,
    parameter int QUO_W = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [31:0]      i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [31:0]      r_den;
    logic [32:0]      r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [33:0]      w_sh;
    logic             w_ge;

    assign w_sh   = {r_rem, r_num[NUM_W-1]};
    assign w_ge   = (w_sh >= {2'b00, r_den});
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= w_ge ? 33'(w_sh - {2'b00, r_den}) : w_sh[32:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

// ===== src/rbsc_back.sv =====
// ----------------------------------------------------------------------------
// rbsc_back: sequencer and datapath
// Runs each queued item as a sequence of steps on one shared fixed-point
// multiplier, with a divider for the mass ratio; holds the body state and
// the output register.
// ----------------------------------------------------------------------------
module rbsc_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rbsc_pkg::t_cfg                    i_cfg,
    input  logic                              i_q_valid,
    input  rbsc_pkg::t_item                   i_q_item,
    output logic                              o_q_pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [rbsc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tuser
);
    import rbsc_pkg::*;

    localparam int NUM_W = FRAC_BITS + 33;
    localparam int QUO_W = FRAC_BITS + 2;
    localparam logic signed [67:0] HALF_P = 68'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [33:0] ONE_Q  = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] HALF_Q = 34'sd1 <<< (FRAC_BITS - 1);

    function automatic logic signed [33:0] s34(input logic signed [31:0] v);
        return 34'(v);
    endfunction

    function automatic logic signed [33:0] u34(input logic [30:0] v);
        return $signed({3'b000, v});
    endfunction

    t_bstate r_state, n_state;

    t_item              r_it;
    logic signed [31:0] r_vel [2];
    logic signed [31:0] r_snap [2];
    logic signed [31:0] r_pos [2];
    logic signed [31:0] r_ang;
    logic               r_axis;
    logic signed [31:0] r_t, r_px, r_py, r_d, r_bvx, r_bvy, r_f;
    logic signed [31:0] r_rx, r_ry, r_ix, r_iy;
    logic               r_contact;
    logic [QUO_W-1:0]   r_w;
    logic               r_bp;
    logic signed [31:0] r_bproj;
    logic signed [17:0] r_bax, r_bay;
    logic signed [31:0] r_bsep, r_bpvx, r_bpvy;
    logic               r_bpk;
    logic [30:0]        r_bpm;
    logic               r_ovalid, r_ouser;
    logic [OUT_DATA_W-1:0] r_odata;

    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod;
    logic signed [31:0] w_fm, w_proj;
    logic [31:0]        w_den;
    logic [NUM_W-1:0]   w_num;
    logic               w_div_start, w_div_done, w_out_free, w_emit;
    logic [QUO_W-1:0]   w_quo;

    // shared multiplier, round half up then saturate
    assign w_prod = w_ma * w_mb;
    assign w_fm   = sat32((w_prod + HALF_P) >>> FRAC_BITS);
    assign w_proj = sadd(s34(r_t), s34(w_fm));

    assign w_den = 32'(i_cfg.mass) + 32'(r_bpm);
    assign w_num = (NUM_W'(r_bpm) << (FRAC_BITS + 1)) + NUM_W'(w_den[31:1]);

    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    rbsc_div #(
        .NUM_W (NUM_W),
        .QUO_W (QUO_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            B_TG:    begin w_ma = r_axis ? s34(i_cfg.gy) : s34(i_cfg.gx);
                           w_mb = u34(r_it.dt); end
            B_TA1:   begin w_ma = s34(r_vel[r_axis]); w_mb = u34(i_cfg.air); end
            B_TA2:   begin w_ma = s34(r_t); w_mb = u34(r_it.dt); end
            B_TP:    begin w_ma = s34(r_vel[r_axis]); w_mb = u34(r_it.dt); end
            B_TANG:  begin w_ma = s34(i_cfg.arate); w_mb = u34(r_it.dt); end
            B_C1:    begin w_ma = 34'(r_it.ax); w_mb = s34(r_it.sep); end
            B_C2:    begin w_ma = 34'(r_it.ay); w_mb = s34(r_it.sep); end
            B_C3:    begin w_ma = s34(r_px); w_mb = s34(r_snap[0]); end
            B_C4:    begin w_ma = s34(r_py); w_mb = s34(r_snap[1]); end
            B_R1:    begin w_ma = 34'(r_bax); w_mb = s34(r_bsep); end
            B_R2:    begin w_ma = 34'(r_bay); w_mb = s34(r_bsep); end
            B_K3:    begin w_ma = s34(r_vel[0]); w_mb = 34'(r_bax); end
            B_K4:    begin w_ma = s34(r_vel[1]); w_mb = 34'(r_bay); end
            B_K5:    begin w_ma = 34'(r_bax); w_mb = s34(r_d); end
            B_K6:    begin w_ma = 34'(r_bay); w_mb = s34(r_d); end
            B_K7:    begin w_ma = s34(r_bvx); w_mb = 34'(i_cfg.bounce); end
            B_K8:    begin w_ma = s34(r_f); w_mb = ONE_Q - 34'(i_cfg.fric); end
            B_K9:    begin w_ma = s34(r_bvy); w_mb = 34'(i_cfg.bounce); end
            B_K10:   begin w_ma = s34(r_f); w_mb = ONE_Q - 34'(i_cfg.fric); end
            B_K11:   begin w_ma = s34(sadd(34'sd0, -s34(r_bvx)));
                           w_mb = u34(i_cfg.mass); end
            B_K12:   begin w_ma = s34(sadd(34'sd0, -s34(r_bvy)));
                           w_mb = u34(i_cfg.mass); end
            B_DH1:   begin w_ma = s34(r_rx); w_mb = HALF_Q; end
            B_DH2:   begin w_ma = s34(r_ry); w_mb = HALF_Q; end
            B_D1:    begin w_ma = $signed({{(34-QUO_W){1'b0}}, r_w});
                           w_mb = s34(r_bpvx) - s34(r_snap[0]); end
            B_D2:    begin w_ma = $signed({{(34-QUO_W){1'b0}}, r_w});
                           w_mb = s34(r_bpvy) - s34(r_snap[1]); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        w_div_start = 1'b0;
        w_emit      = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    case (i_q_item.kind)
                        K_TICK:  n_state = B_TG;
                        K_CAND:  n_state = B_C1;
                        default: n_state = B_EMIT;
                    endcase
                end
            end
            B_TG:   n_state = B_TA1;
            B_TA1:  n_state = B_TA2;
            B_TA2:  n_state = B_TP;
            B_TP:   n_state = r_axis ? B_TANG : B_TG;
            B_TANG: n_state = B_EMIT;
            B_C1:   n_state = B_C2;
            B_C2:   n_state = B_C3;
            B_C3:   n_state = B_C4;
            B_C4:   n_state = r_it.last ? B_R1 : B_EMIT;
            B_R1:   n_state = B_R2;
            B_R2:   n_state = r_bpk ? B_K3 : B_DH1;
            B_K3:   n_state = B_K4;
            B_K4:   n_state = B_K5;
            B_K5:   n_state = B_K6;
            B_K6:   n_state = B_K7;
            B_K7:   n_state = B_K8;
            B_K8:   n_state = B_K9;
            B_K9:   n_state = B_K10;
            B_K10:  n_state = B_K11;
            B_K11:  n_state = B_K12;
            B_K12:  n_state = B_POS;
            B_DH1:  n_state = B_DH2;
            B_DH2:  n_state = B_DIV;
            B_DIV: begin
                if (w_den == 32'd0) begin
                    n_state = B_D1;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = B_DWAIT;
                end
            end
            B_DWAIT: n_state = w_div_done ? B_D1 : B_DWAIT;
            B_D1:   n_state = B_D2;
            B_D2:   n_state = B_D3;
            B_D3:   n_state = B_POS;
            B_POS:  n_state = B_EMIT;
            B_EMIT: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel[0]  <= '0;
            r_vel[1]  <= '0;
            r_snap[0] <= '0;
            r_snap[1] <= '0;
            r_pos[0]  <= '0;
            r_pos[1]  <= '0;
            r_ang     <= '0;
            r_bp      <= 1'b0;
            r_bproj   <= 32'sh7FFF_FFFF;
            r_ovalid  <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_it      <= i_q_item;
                        r_axis    <= 1'b0;
                        r_contact <= 1'b0;
                        r_rx      <= '0;
                        r_ry      <= '0;
                        r_ix      <= '0;
                        r_iy      <= '0;
                        if (i_q_item.kind == K_IGN && i_q_item.last) begin
                            r_bp    <= 1'b0;
                            r_bproj <= 32'sh7FFF_FFFF;
                        end
                    end
                end
                B_TG: begin
                    if (i_cfg.flags[FLG_GRAV]) begin
                        r_vel[r_axis] <= sadd(s34(r_vel[r_axis]), s34(w_fm));
                    end
                end
                B_TA1: r_t <= w_fm;
                B_TA2: r_vel[r_axis] <= sadd(s34(r_vel[r_axis]), -s34(w_fm));
                B_TP: begin
                    r_pos[r_axis]  <= sadd(s34(r_pos[r_axis]), s34(w_fm));
                    r_snap[r_axis] <= r_vel[r_axis];
                    r_axis         <= 1'b1;
                end
                B_TANG: r_ang <= r_ang + w_fm;
                B_C1: r_px <= w_fm;
                B_C2: r_py <= w_fm;
                B_C3: r_t  <= w_fm;
                B_C4: begin
                    // keep the least projection in the group
                    if (!r_bp || w_proj < r_bproj) begin
                        r_bp    <= 1'b1;
                        r_bproj <= w_proj;
                        r_bax   <= r_it.ax;
                        r_bay   <= r_it.ay;
                        r_bsep  <= r_it.sep;
                        r_bpk   <= r_it.pk;
                        r_bpm   <= r_it.pm;
                        r_bpvx  <= r_it.pvx;
                        r_bpvy  <= r_it.pvy;
                    end
                end
                B_R1:  r_rx  <= sadd(34'sd0, -s34(w_fm));
                B_R2:  r_ry  <= sadd(34'sd0, -s34(w_fm));
                B_K3:  r_t   <= w_fm;
                B_K4:  r_d   <= sadd(s34(r_t), s34(w_fm));
                B_K5:  r_bvx <= w_fm;
                B_K6:  r_bvy <= w_fm;
                B_K7: begin
                    r_t <= w_fm;
                    r_f <= sadd(s34(r_vel[0]), -s34(r_bvx));
                end
                B_K8:  r_vel[0] <= sadd(s34(r_t), s34(w_fm));
                B_K9: begin
                    r_t <= w_fm;
                    r_f <= sadd(s34(r_vel[1]), -s34(r_bvy));
                end
                B_K10: r_vel[1] <= sadd(s34(r_t), s34(w_fm));
                B_K11: r_ix <= w_fm;
                B_K12: r_iy <= w_fm;
                B_DH1: r_rx <= w_fm;
                B_DH2: r_ry <= w_fm;
                B_DIV: begin
                    if (w_den == 32'd0) begin
                        r_w <= '0;
                    end
                end
                B_DWAIT: begin
                    if (w_div_done) begin
                        r_w <= w_quo;
                    end
                end
                B_D1: r_vel[0] <= sadd(s34(r_snap[0]), s34(w_fm));
                B_D2: begin
                    r_vel[1] <= sadd(s34(r_snap[1]), s34(w_fm));
                    r_ix     <= sadd(s34(r_vel[0]), -s34(r_snap[0]));
                end
                B_D3: r_iy <= sadd(s34(r_vel[1]), -s34(r_snap[1]));
                B_POS: begin
                    r_pos[0]  <= sadd(s34(r_pos[0]), s34(r_rx));
                    r_pos[1]  <= sadd(s34(r_pos[1]), s34(r_ry));
                    r_contact <= 1'b1;
                    r_bp      <= 1'b0;
                    r_bproj   <= 32'sh7FFF_FFFF;
                end
                B_EMIT: begin
                    if (w_emit) begin
                        r_ouser  <= r_contact;
                        r_odata  <= {r_iy, r_ix, r_ry, r_rx, r_ang,
                                     r_vel[1], r_vel[0], r_pos[1], r_pos[0]};
                        if (r_it.kind == K_CAND && r_it.last) begin
                            r_bp    <= 1'b0;
                            r_bproj <= 32'sh7FFF_FFFF;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid)
        else $error("result dropped while stalled");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_state != B_IDLE)
        else $error("item popped but sequencer stayed idle");

    a_best_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_POS |=> !r_bp)
        else $error("selection not cleared after resolve");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> r_state == B_DIV && w_den != 32'd0)
        else $error("divider started outside its step");

endmodule

// ===== src/rigid_body_2d_step_and_collision.sv =====
// ----------------------------------------------------------------------------
// rigid_body_2d_step_and_collision: 2D body integrator with collision response
// Front stage queues and classifies items; the back sequencer integrates
// ticks and selects and resolves collision candidates.
//
// channel  | direction | handshake              | payload
// s_axis   | in        | tvalid/tready          | tdata item fields, tuser op,
//          |           |                        | tlast group_last
// m_axis   | out       | tvalid/tready          | tdata state/result, tuser contact
// cfg      | in        | i_cfg_we (no wait)     | i_cfg_idx, i_cfg_data
//
// One shared multiplier does one product per cycle while the sequencer steps;
// items are run one at a time, and a dynamic resolve waits on the restoring
// divider. Up to two items queue ahead of the sequencer; a stalled output
// holds the sequencer in its last step. Reset is synchronous.
// ----------------------------------------------------------------------------
module rigid_body_2d_step_and_collision #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [2:0]                       i_cfg_idx,
    input  logic [31:0]                      i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // time_step[30:0] axis_x[48:31] axis_y[66:49] separation[98:67]
    // partner_kinematic[99] partner_mass[130:100] partner_vel_x[162:131]
    // partner_vel_y[194:163], zero pad to 199
    input  logic [rbsc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tuser,  // operation
    input  logic                             s_axis_tlast,  // group_last
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // pos_x pos_y vel_x vel_y angle resolve_x resolve_y impulse_x impulse_y,
    // 32 bits each from bit 0 up
    output logic [rbsc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tuser   // contact_valid
);
    import rbsc_pkg::*;

    t_cfg  r_cfg;
    t_item w_q_item;
    logic  w_q_valid, w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gx     <= '0;
            r_cfg.gy     <= -(32'sd1 <<< FRAC_BITS);
            r_cfg.air    <= '0;
            r_cfg.fric   <= '0;
            r_cfg.bounce <= '0;
            r_cfg.mass   <= 31'd1 << FRAC_BITS;
            r_cfg.arate  <= '0;
            r_cfg.flags  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GX:     r_cfg.gx     <= i_cfg_data;
                CFG_GY:     r_cfg.gy     <= i_cfg_data;
                CFG_AIR:    r_cfg.air    <= i_cfg_data[30:0];
                CFG_FRIC:   r_cfg.fric   <= i_cfg_data[16:0];
                CFG_BOUNCE: r_cfg.bounce <= i_cfg_data[17:0];
                CFG_MASS:   r_cfg.mass   <= i_cfg_data[30:0];
                CFG_ARATE:  r_cfg.arate  <= i_cfg_data;
                CFG_FLAGS:  r_cfg.flags  <= i_cfg_data[2:0];
                default:    ;
            endcase
        end
    end

    rbsc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .i_cfg         (r_cfg),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item),
        .i_q_pop       (w_q_pop)
    );

    rbsc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== tb/sv/rbsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsc_checker: result predictor and comparator
// Watches the config port and both stream channels, keeps its own copy of the
// body state, predicts one result per accepted input transfer and compares
// every output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rbsc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_idx,
    input  logic [31:0]                     i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [rbsc_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic                            i_in_op,
    input  logic                            i_in_last,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [rbsc_pkg::OUT_DATA_W-1:0] i_out_data,
    input  logic                            i_out_contact,
    output int                              o_fail_count,
    output int                              o_pending
);
    import rbsc_pkg::*;

    localparam int F = 16;
    localparam longint ONE = 64'sd1 <<< F;
    localparam longint HALF = 64'sd1 <<< (F - 1);

    typedef struct {
        logic [OUT_DATA_W-1:0] data;
        logic                  contact;
    } t_body_result;

    t_body_result expected_results[$];

    longint gx, gy, air, fric, bnc, mass, arate;
    logic [2:0] flags;
    longint vel[2], snap[2], pos[2];
    logic [31:0] ang;
    longint best_proj;
    logic held;
    longint h_ax, h_ay, h_sep, h_pm, h_pvx, h_pvy;
    logic h_pk;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return clamp32((a * b + HALF) >>> F);
    endfunction

    function automatic longint sext32(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint sext18(input logic [17:0] v);
        return longint'($signed(v));
    endfunction

    task automatic drop_held();
        held = 1'b0;
        best_proj = 64'sd2147483647;
        h_ax = 0; h_ay = 0; h_sep = 0; h_pk = 0; h_pm = 0; h_pvx = 0; h_pvy = 0;
    endtask

    task automatic predict_item(input logic op, input logic last,
                                input logic [IN_DATA_W-1:0] d);
        longint dt, ax, ay, sep, px, py, proj, nx, ny, dot, b[2], fv[2], w, den, pm;
        longint rx, ry, ix, iy;
        logic contact;
        t_body_result r;
        rx = 0; ry = 0; ix = 0; iy = 0; contact = 1'b0;
        dt = longint'(d[30:0]);
        if (op == OP_TICK) begin
            for (int i = 0; i < 2; i++) begin
                if (flags[FLG_GRAV])
                    vel[i] = clamp32(vel[i] + qmul(i ? gy : gx, dt));
                vel[i] = clamp32(vel[i] - qmul(qmul(vel[i], air), dt));
                pos[i] = clamp32(pos[i] + qmul(vel[i], dt));
                snap[i] = vel[i];
            end
            ang = ang + 32'(qmul(arate, dt));
        end else if (!flags[FLG_SOLID] || flags[FLG_KIN]) begin
            if (last) drop_held();
        end else begin
            ax = sext18(d[48:31]);
            ay = sext18(d[66:49]);
            sep = sext32(d[98:67]);
            px = qmul(ax, sep);
            py = qmul(ay, sep);
            proj = clamp32(qmul(px, snap[0]) + qmul(py, snap[1]));
            if (!held || proj < best_proj) begin
                held = 1'b1;
                best_proj = proj;
                h_ax = ax; h_ay = ay; h_sep = sep; h_pk = d[99];
                h_pm = longint'(d[130:100]);
                h_pvx = sext32(d[162:131]);
                h_pvy = sext32(d[194:163]);
            end
            if (last && held) begin
                nx = clamp32(-qmul(h_ax, h_sep));
                ny = clamp32(-qmul(h_ay, h_sep));
                if (h_pk) begin
                    rx = nx; ry = ny;
                    dot = clamp32(qmul(vel[0], h_ax) + qmul(vel[1], h_ay));
                    b[0] = qmul(h_ax, dot);
                    b[1] = qmul(h_ay, dot);
                    for (int i = 0; i < 2; i++) fv[i] = clamp32(vel[i] - b[i]);
                    for (int i = 0; i < 2; i++)
                        vel[i] = clamp32(qmul(b[i], bnc) + qmul(fv[i], ONE - fric));
                    ix = qmul(clamp32(-b[0]), mass);
                    iy = qmul(clamp32(-b[1]), mass);
                end else begin
                    rx = qmul(nx, HALF);
                    ry = qmul(ny, HALF);
                    pm = h_pm;
                    den = mass + pm;
                    w = (den != 0) ? ((pm <<< (F + 1)) + den / 2) / den : 0;
                    vel[0] = clamp32(snap[0] + qmul(w, h_pvx - snap[0]));
                    vel[1] = clamp32(snap[1] + qmul(w, h_pvy - snap[1]));
                    ix = clamp32(vel[0] - snap[0]);
                    iy = clamp32(vel[1] - snap[1]);
                end
                pos[0] = clamp32(pos[0] + rx);
                pos[1] = clamp32(pos[1] + ry);
                contact = 1'b1;
            end
            if (last) drop_held();
        end
        r.data = {32'(iy), 32'(ix), 32'(ry), 32'(rx), ang,
                  32'(vel[1]), 32'(vel[0]), 32'(pos[1]), 32'(pos[0])};
        r.contact = contact;
        expected_results.push_back(r);
    endtask

    task automatic compare_result();
        t_body_result e;
        string names[9] = '{"pos_x", "pos_y", "vel_x", "vel_y", "angle",
                            "resolve_x", "resolve_y", "impulse_x", "impulse_y"};
        if (expected_results.size() == 0) begin
            $error("result transfer with no prediction pending");
            o_fail_count++;
            return;
        end
        e = expected_results.pop_front();
        for (int i = 0; i < 9; i++) begin
            if (i_out_data[32*i +: 32] !== e.data[32*i +: 32]) begin
                $error("%s: expected %h, got %h", names[i], e.data[32*i +: 32],
                       i_out_data[32*i +: 32]);
                o_fail_count++;
            end
        end
        if (i_out_contact !== e.contact) begin
            $error("contact_valid: expected %b, got %b", e.contact, i_out_contact);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gx = 0; gy = -ONE; air = 0; fric = 0; bnc = 0; mass = ONE; arate = 0;
            flags = 3'd0;
            for (int i = 0; i < 2; i++) begin
                vel[i] = 0; snap[i] = 0; pos[i] = 0;
            end
            ang = 32'd0;
            drop_held();
            expected_results.delete();
            o_fail_count = 0;
            o_pending = 0;
        end else begin
            // result side first: a prediction made this edge cannot be consumed now
            if (i_out_valid && i_out_ready) compare_result();
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GX:     gx = sext32(i_cfg_data);
                    CFG_GY:     gy = sext32(i_cfg_data);
                    CFG_AIR:    air = longint'(i_cfg_data[30:0]);
                    CFG_FRIC:   fric = longint'(i_cfg_data[16:0]);
                    CFG_BOUNCE: bnc = sext18(i_cfg_data[17:0]);
                    CFG_MASS:   mass = longint'(i_cfg_data[30:0]);
                    CFG_ARATE:  arate = sext32(i_cfg_data);
                    CFG_FLAGS:  flags = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_item(i_in_op, i_in_last, i_in_data);
            o_pending = expected_results.size();
        end
    end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: rigid body step and collision regression
// Drives directed and random ticks and collision groups across several
// configurations with random idling and a long output hold-off; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import rbsc_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = CFG_GX;
    logic [31:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;  // dt ax ay sep pk pm pvx pvy, bit 0 up
    logic s_axis_tuser = OP_TICK;             // operation
    logic s_axis_tlast = 1'b0;                // group_last
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;      // pos vel angle resolve impulse
    logic m_axis_tuser;                       // contact_valid

    int fail_count, pending;
    bit calm_phase = 1'b0;
    bit hold_out = 1'b0;
    int idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rigid_body_2d_step_and_collision dut (.*);

    rbsc_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_op(s_axis_tuser), .i_in_last(s_axis_tlast),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_contact(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: bursts of stall, or a forced long hold-off
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                m_axis_tready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 17);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one write, then the enable is driven low again before the task returns
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic stop_input();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        stop_input();
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // tvalid stays high on return so items can follow back to back
    task automatic send(input logic op, input logic last, input logic [30:0] dt,
                        input logic [17:0] ax, input logic [17:0] ay,
                        input logic [31:0] sep, input logic pk,
                        input logic [30:0] pm, input logic [31:0] pvx,
                        input logic [31:0] pvy);
        int n;
        if (!calm_phase && $urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 17);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tlast <= last;
        s_axis_tdata <= {5'd0, pvy, pvx, pm, pk, sep, ay, ax, dt};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [17:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 18'h10000;
            1: return 18'h30000;
            2: return 18'd0;
            default: return 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic logic [31:0] rand_wide(input int shift);
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 9) == 0) return v;
        return 32'($signed(v) >>> shift);
    endfunction

    task automatic rand_tick();
        logic [30:0] dt;
        dt = ($urandom_range(0, 19) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32768));
        send(OP_TICK, 1'($urandom_range(0, 1)), dt, 18'($urandom), 18'($urandom),
             $urandom, 1'($urandom_range(0, 1)), 31'($urandom), $urandom, $urandom);
    endtask

    task automatic rand_group();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            send(OP_CAND, i == n - 1, 31'($urandom), rand_axis(), rand_axis(),
                 rand_wide($urandom_range(8, 14)), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(1, 400000)),
                 rand_wide($urandom_range(8, 14)), rand_wide($urandom_range(8, 14)));
        end
    endtask

    task automatic config_set(input int sel);
        case (sel)
            0: begin
                write_reg(CFG_GX, 32'h0000_4000);
                write_reg(CFG_GY, 32'hFFFF_0000);
                write_reg(CFG_AIR, 32'h0000_0800);
                write_reg(CFG_FRIC, 32'h0000_2000);
                write_reg(CFG_BOUNCE, 32'h3_8000);
                write_reg(CFG_MASS, 32'h0001_0000);
                write_reg(CFG_ARATE, 32'h0000_C000);
                write_reg(CFG_FLAGS, 32'd5);
            end
            1: begin
                write_reg(CFG_GX, 32'h8000_0000);
                write_reg(CFG_GY, 32'h7FFF_FFFF);
                write_reg(CFG_AIR, 32'h7FFF_FFFF);
                write_reg(CFG_FRIC, 32'h0001_0000);
                write_reg(CFG_BOUNCE, 32'h1_0000);
                write_reg(CFG_MASS, 32'h7FFF_FFFF);
                write_reg(CFG_ARATE, 32'h7FFF_FFFF);
                write_reg(CFG_FLAGS, 32'd7);
            end
            2: begin
                write_reg(CFG_AIR, 32'd0);
                write_reg(CFG_FRIC, 32'd0);
                write_reg(CFG_BOUNCE, 32'h3_0000);
                write_reg(CFG_MASS, 32'd1);
                write_reg(CFG_ARATE, 32'h8000_0000);
                write_reg(CFG_FLAGS, 32'd1);
            end
            default: begin
                write_reg(CFG_GX, $urandom);
                write_reg(CFG_GY, rand_wide(12));
                write_reg(CFG_AIR, $urandom_range(0, 8192));
                write_reg(CFG_FRIC, $urandom_range(0, 65536));
                write_reg(CFG_BOUNCE, 32'($signed($urandom_range(0, 131072)) - 65536));
                write_reg(CFG_MASS, $urandom_range(1, 1 << 20));
                write_reg(CFG_ARATE, $urandom);
                // solid and dynamic most of the time
                write_reg(CFG_FLAGS, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                     : (($urandom_range(0, 1) << FLG_GRAV) | 1));
            end
        endcase
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config, then extremes of each case
        send(OP_TICK, 1'b0, 31'h0001_0000, 0, 0, 0, 0, 1, 0, 0);
        send(OP_CAND, 1'b1, 0, 18'h10000, 0, 32'h1_0000, 1'b0, 31'd1, 0, 0);
        drain();
        config_set(0);
        send(OP_TICK, 1'b0, 31'h0000_8000, 0, 0, 0, 0, 1, 0, 0);
        send(OP_TICK, 1'b0, 31'd0, 0, 0, 0, 0, 1, 0, 0);
        send(OP_CAND, 1'b0, 0, 18'h10000, 0, 32'h0002_0000, 1'b1, 31'd1, 0, 0);
        send(OP_CAND, 1'b1, 0, 0, 18'h30000, 32'h0000_8000, 1'b1, 31'd1, 0, 0);
        send(OP_CAND, 1'b1, 0, 18'h10000, 18'h10000, 32'h8000_0000, 1'b0,
             31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send(OP_CAND, 1'b1, 0, 18'h30000, 0, 32'h7FFF_FFFF, 1'b0, 31'd1,
             32'h8000_0000, 32'h7FFF_FFFF);
        drain();
        config_set(1);
        send(OP_TICK, 1'b0, 31'h7FFF_FFFF, 0, 0, 0, 0, 1, 0, 0);
        send(OP_CAND, 1'b1, 0, 18'h10000, 0, 32'h1_0000, 1'b1, 31'd1, 0, 0);
        drain();
        write_reg(CFG_FLAGS, 32'd1);
        send(OP_CAND, 1'b1, 0, 18'h10000, 0, 32'h1_0000, 1'b1, 31'd5, 0, 0);
        send(OP_CAND, 1'b1, 0, 18'h10000, 0, 32'h1_0000, 1'b0, 31'h7FFF_FFFF, 1, 2);
        drain();
        config_set(2);
        send(OP_TICK, 1'b0, 31'h0000_4000, 0, 0, 0, 0, 1, 0, 0);
        send(OP_CAND, 1'b1, 0, 18'h20000, 18'h1FFFF, 32'h1234_5678, 1'b0, 31'd1,
             32'h0010_0000, 32'hFFF0_0000);
        drain();

        // random phases; output held off during one to fill the block
        for (int ph = 0; ph < 10; ph++) begin
            config_set(3 + ph);
            if (ph == 2) begin
                hold_out = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge i_clk);
                        hold_out = 1'b0;
                    end
                join_none
            end
            if (ph == 9) calm_phase = 1'b1;
            for (int k = 0; k < 85; k++) begin
                if ($urandom_range(0, 2) == 0) rand_tick();
                else rand_group();
                if (k == 80 && ph == 4) begin
                    stop_input();
                    while (pending != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
